>>> rtl/knol_pkg.sv
// shared types, token kind codes and keyword tables for the lexer
// no dependencies; imported by every lexer module
package knol_pkg;

  localparam int unsigned PosWidthDefault = 32;
  localparam int unsigned LenWidthDefault = 16;
  localparam int unsigned StartWidth      = 32;
  localparam int unsigned LengthWidth     = 16;
  localparam int unsigned KindWidth       = 5;
  localparam int unsigned NumKeywords     = 8;
  localparam int unsigned QueueDepth      = 4;

  // token kinds
  localparam logic [KindWidth-1:0] KIND_END    = 5'd0;
  localparam logic [KindWidth-1:0] KIND_IDENT  = 5'd9;
  localparam logic [KindWidth-1:0] KIND_NUMBER = 5'd10;
  localparam logic [KindWidth-1:0] KIND_LPAREN = 5'd11;
  localparam logic [KindWidth-1:0] KIND_RPAREN = 5'd12;
  localparam logic [KindWidth-1:0] KIND_COMMA  = 5'd13;
  localparam logic [KindWidth-1:0] KIND_SEMI   = 5'd14;
  localparam logic [KindWidth-1:0] KIND_PLUS   = 5'd15;
  localparam logic [KindWidth-1:0] KIND_MINUS  = 5'd16;
  localparam logic [KindWidth-1:0] KIND_STAR   = 5'd17;
  localparam logic [KindWidth-1:0] KIND_LESS   = 5'd18;
  localparam logic [KindWidth-1:0] KIND_EQUAL  = 5'd19;
  localparam logic [KindWidth-1:0] KIND_BANG   = 5'd20;
  localparam logic [KindWidth-1:0] KIND_ERROR  = 5'd21;

  typedef struct packed {
    logic [KindWidth-1:0]   kind;
    logic [StartWidth-1:0]  start;
    logic [LengthWidth-1:0] length;
  } knol_tok_t;

  // tokens caused by one input word: first slot always used, second when two is set
  typedef struct packed {
    knol_tok_t first;
    knol_tok_t second;
    logic      two;
  } knol_rec_t;

  typedef struct packed {
    logic      push;
    knol_rec_t rec;
  } knol_wr_t;

  // keyword length, in bytes
  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] r;
    unique case (k)
      3'd0:    r = 3'd3; // def
      3'd1:    r = 3'd6; // extern
      3'd2:    r = 3'd2; // if
      3'd3:    r = 3'd4; // then
      3'd4:    r = 3'd4; // else
      3'd5:    r = 3'd3; // for
      3'd6:    r = 3'd2; // in
      default: r = 3'd3; // var
    endcase
    return r;
  endfunction

  // keyword byte at position i, zero past the end
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
    logic [47:0] s;
    logic [7:0]  r;
    unique case (k)
      3'd0:    s = {"d", "e", "f", 8'h00, 8'h00, 8'h00};
      3'd1:    s = {"e", "x", "t", "e", "r", "n"};
      3'd2:    s = {"i", "f", 8'h00, 8'h00, 8'h00, 8'h00};
      3'd3:    s = {"t", "h", "e", "n", 8'h00, 8'h00};
      3'd4:    s = {"e", "l", "s", "e", 8'h00, 8'h00};
      3'd5:    s = {"f", "o", "r", 8'h00, 8'h00, 8'h00};
      3'd6:    s = {"i", "n", 8'h00, 8'h00, 8'h00, 8'h00};
      default: s = {"v", "a", "r", 8'h00, 8'h00, 8'h00};
    endcase
    unique case (i)
      3'd0:    r = s[47:40];
      3'd1:    r = s[39:32];
      3'd2:    r = s[31:24];
      3'd3:    r = s[23:16];
      3'd4:    r = s[15:8];
      3'd5:    r = s[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // single character operators, error for anything else
  function automatic logic [KindWidth-1:0] op_kind(input logic [7:0] c);
    logic [KindWidth-1:0] r;
    unique case (c)
      "(":     r = KIND_LPAREN;
      ")":     r = KIND_RPAREN;
      ",":     r = KIND_COMMA;
      ";":     r = KIND_SEMI;
      "+":     r = KIND_PLUS;
      "-":     r = KIND_MINUS;
      "*":     r = KIND_STAR;
      "<":     r = KIND_LESS;
      "=":     r = KIND_EQUAL;
      "!":     r = KIND_BANG;
      default: r = KIND_ERROR;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/knol_front.sv
// front end: classifies each byte, keeps the running token state, builds token records
// depends on knol_pkg
module knol_front import knol_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = PosWidthDefault,
  parameter int unsigned LENGTH_WIDTH   = LenWidthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  logic [7:0] ch_i,
  input  logic     end_marker_i,
  output knol_wr_t wr_o
);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;

  logic [1:0]                mode_q, mode_d;
  logic                      seen_dot_q, seen_dot_d;
  logic [NumKeywords-1:0]    alive_q, alive_d;
  logic [LENGTH_WIDTH-1:0]   len_q, len_d;
  logic [POSITION_WIDTH-1:0] start_q, start_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic                      halted_q, halted_d;

  logic is_space, is_digit, is_alpha, is_under, is_dot;
  logic ident_ch, num_ch, ident_first;
  logic cont_ident, cont_num, cont;
  logic [NumKeywords-1:0] alive_app, alive_begin;
  logic [LENGTH_WIDTH-1:0] len_inc;
  logic len_lt8;
  logic [2:0] li;
  logic [KindWidth-1:0] ident_kind, op_k;
  logic [63:0] start_ext, pos_ext;
  logic [31:0] len_ext;
  knol_tok_t ft, st;
  logic ft_valid, st_valid;

  always_comb begin
    is_space    = (ch_i == 8'd32) || (ch_i >= 8'd9 && ch_i <= 8'd13);
    is_digit    = ch_i >= "0" && ch_i <= "9";
    is_alpha    = (ch_i >= "a" && ch_i <= "z") || (ch_i >= "A" && ch_i <= "Z");
    is_under    = ch_i == "_";
    is_dot      = ch_i == ".";
    ident_first = is_alpha || is_under;
    ident_ch    = ident_first || is_digit;
    num_ch      = is_digit || is_dot;
    cont_ident  = (mode_q == MODE_IDENT) && ident_ch;
    cont_num    = (mode_q == MODE_NUMBER) && num_ch && !(is_dot && seen_dot_q);
    cont        = cont_ident || cont_num;
  end

  // keyword alive mask update and saturating length
  always_comb begin
    len_lt8 = len_q < LENGTH_WIDTH'(8);
    li      = len_q[2:0];
    for (int k = 0; k < NumKeywords; k++) begin
      alive_app[k] = alive_q[k] && len_lt8 && (li < kw_len(3'(k)))
                     && (kw_char(3'(k), li) == ch_i);
      alive_begin[k] = kw_char(3'(k), 3'd0) == ch_i;
    end
    len_inc = (len_q == '1) ? len_q : len_q + LENGTH_WIDTH'(1);
  end

  // keyword lookup on flush, lowest index wins
  always_comb begin
    ident_kind = KIND_IDENT;
    for (int k = NumKeywords - 1; k >= 0; k--) begin
      if (alive_q[k] && (len_q == LENGTH_WIDTH'(kw_len(3'(k))))) begin
        ident_kind = KindWidth'(k + 1);
      end
    end
  end

  always_comb begin
    start_ext = 64'(start_q);
    pos_ext   = 64'(pos_q);
    len_ext   = 32'(len_q);
    op_k      = op_kind(ch_i);

    ft_valid     = (mode_q != MODE_IDLE) && (end_marker_i || (!halted_q && !cont));
    ft.kind      = (mode_q == MODE_IDENT) ? ident_kind : KIND_NUMBER;
    ft.start     = start_ext[StartWidth-1:0];
    ft.length    = len_ext[LengthWidth-1:0];

    st.start = pos_ext[StartWidth-1:0];
    if (end_marker_i) begin
      st_valid  = 1'b1;
      st.kind   = KIND_END;
      st.length = '0;
    end else begin
      st_valid  = !halted_q && !cont && !is_space && !ident_first && !num_ch;
      st.kind   = op_k;
      st.length = LengthWidth'(1);
    end

    wr_o.push       = accept_i && (ft_valid || st_valid);
    wr_o.rec.first  = ft_valid ? ft : st;
    wr_o.rec.second = st;
    wr_o.rec.two    = ft_valid && st_valid;
  end

  always_comb begin
    mode_d     = mode_q;
    seen_dot_d = seen_dot_q;
    alive_d    = alive_q;
    len_d      = len_q;
    start_d    = start_q;
    pos_d      = pos_q;
    halted_d   = halted_q;
    if (accept_i) begin
      if (end_marker_i) begin
        // stream ends, back to the reset state
        mode_d     = MODE_IDLE;
        seen_dot_d = 1'b0;
        alive_d    = '1;
        len_d      = '0;
        start_d    = '0;
        pos_d      = '0;
        halted_d   = 1'b0;
      end else begin
        pos_d = pos_q + POSITION_WIDTH'(1);
        if (!halted_q) begin
          if (cont_ident) begin
            alive_d = alive_app;
            len_d   = len_inc;
          end else if (cont_num) begin
            seen_dot_d = seen_dot_q || is_dot;
            len_d      = len_inc;
          end else if (ident_first) begin
            mode_d     = MODE_IDENT;
            seen_dot_d = 1'b0;
            alive_d    = alive_begin;
            len_d      = LENGTH_WIDTH'(1);
            start_d    = pos_q;
          end else if (num_ch) begin
            mode_d     = MODE_NUMBER;
            seen_dot_d = is_dot;
            alive_d    = '1;
            len_d      = LENGTH_WIDTH'(1);
            start_d    = pos_q;
          end else begin
            // separator, operator or bad byte
            mode_d     = MODE_IDLE;
            seen_dot_d = 1'b0;
            alive_d    = '1;
            len_d      = '0;
            start_d    = '0;
            if (!is_space && op_k == KIND_ERROR) begin
              halted_d = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      seen_dot_q <= 1'b0;
      alive_q    <= '1;
      len_q      <= '0;
      start_q    <= '0;
      pos_q      <= '0;
      halted_q   <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      seen_dot_q <= seen_dot_d;
      alive_q    <= alive_d;
      len_q      <= len_d;
      start_q    <= start_d;
      pos_q      <= pos_d;
      halted_q   <= halted_d;
    end
  end

endmodule

>>> rtl/knol_queue.sv
// short record queue between the front end and the token emitter
// depends on knol_pkg
module knol_queue import knol_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  knol_wr_t  wr_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      empty_o,
  output knol_rec_t rec_o
);

  localparam int unsigned PtrWidth = $clog2(QueueDepth);
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);
  localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(QueueDepth - 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(QueueDepth);

  knol_rec_t           mem_q [QueueDepth];
  logic [PtrWidth-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == CntFull;
  assign empty_o = cnt_q == '0;
  assign rec_o   = mem_q[rptr_q];
  assign do_push = wr_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + PtrWidth'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + PtrWidth'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntWidth'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wr_i.rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> rtl/knol_back.sv
// back end: splits records into single token words behind an output register
// depends on knol_pkg
module knol_back import knol_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  knol_rec_t              rec_i,
  output logic                   q_pop_o,
  input  logic                   pop,
  output logic                   empty,
  output logic [KindWidth-1:0]   kind_o,
  output logic [StartWidth-1:0]  start_offset_o,
  output logic [LengthWidth-1:0] length_o,
  output logic                   last_o
);

  logic      out_valid_q, out_valid_d;
  knol_tok_t out_tok_q, out_tok_d;
  logic      out_last_q, out_last_d;
  logic      pend_valid_q, pend_valid_d;
  knol_tok_t pend_tok_q, pend_tok_d;
  logic      advance;

  assign advance = !out_valid_q || pop;
  assign q_pop_o = advance && !pend_valid_q && !q_empty_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_tok_d    = out_tok_q;
    out_last_d   = out_last_q;
    pend_valid_d = pend_valid_q;
    pend_tok_d   = pend_tok_q;
    if (advance) begin
      if (pend_valid_q) begin
        // second token of the previous word
        out_valid_d  = 1'b1;
        out_tok_d    = pend_tok_q;
        out_last_d   = 1'b1;
        pend_valid_d = 1'b0;
      end else if (!q_empty_i) begin
        out_valid_d  = 1'b1;
        out_tok_d    = rec_i.first;
        out_last_d   = !rec_i.two;
        pend_valid_d = rec_i.two;
        pend_tok_d   = rec_i.second;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_tok_q  <= out_tok_d;
    out_last_q <= out_last_d;
    pend_tok_q <= pend_tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  assign empty          = !out_valid_q;
  assign kind_o         = out_tok_q.kind;
  assign start_offset_o = out_tok_q.start;
  assign length_o       = out_tok_q.length;
  assign last_o         = out_last_q;

endmodule

>>> rtl/keyword_number_operator_lexer.sv
// lexer top level: one byte word per cycle in while the record queue is not full, token words out
// a token word reaches the outputs through the record queue and then the back end output register
// a byte giving two tokens leaves as two token words, the first and then the second, on the output side
// a four entry record queue sets how long the input keeps flowing while the output stalls
// reset clears position, token state and the halt flag at once; there is no clearing pass
// depends on knol_pkg, knol_front, knol_queue and knol_back
module keyword_number_operator_lexer import knol_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = PosWidthDefault,
  parameter int unsigned LENGTH_WIDTH   = LenWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // byte side, queue-like
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             ch_i,
  input  logic                   end_marker_i,
  // token side, queue-like
  output logic                   empty,
  input  logic                   pop,
  output logic [KindWidth-1:0]   kind_o,
  output logic [StartWidth-1:0]  start_offset_o,
  output logic [LengthWidth-1:0] length_o,
  output logic                   last_o
);

  knol_wr_t  wr;
  knol_rec_t rec;
  logic      accept;
  logic      q_empty;
  logic      q_pop;

  // a byte is taken whenever the record queue has room, even if it makes no token
  assign accept = push && !full;

  // front end: per-byte classification and token state
  knol_front #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .LENGTH_WIDTH  (LENGTH_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .ch_i        (ch_i),
    .end_marker_i(end_marker_i),
    .wr_o        (wr)
  );

  // decoupling queue, one record per byte that made tokens
  knol_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .pop_i  (q_pop),
    .full_o (full),
    .empty_o(q_empty),
    .rec_o  (rec)
  );

  // back end: one token word at a time, last flag on the final token of a byte
  knol_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .rec_i         (rec),
    .q_pop_o       (q_pop),
    .pop           (pop),
    .empty         (empty),
    .kind_o        (kind_o),
    .start_offset_o(start_offset_o),
    .length_o      (length_o),
    .last_o        (last_o)
  );

endmodule

>>> tb/keyword_number_operator_lexer_tb.sv
// self-checking testbench for keyword_number_operator_lexer: directed table,
// then random token streams checked against a local lexer
// depends on knol_pkg and the keyword_number_operator_lexer rtl
module keyword_number_operator_lexer_tb;
  import knol_pkg::*;

  // keyword kinds follow in table order: def extern if then else for in var
  localparam logic [KindWidth-1:0] KIND_DEF = 5'd1;

  localparam int unsigned RANDOM_WORDS = 1750;
  localparam int unsigned DRAIN_EVERY  = 400;
  localparam int unsigned STALL_LIMIT  = 1000;   // cycles with no word moving on either side
  localparam int unsigned SETTLE       = 40;     // extra cycles after the last token word

  // keyword spellings, right justified, with their lengths
  localparam logic [47:0] KW_TEXT [8] = '{"def", "extern", "if", "then",
                                          "else", "for", "in", "var"};
  localparam int KW_LEN [8] = '{3, 6, 2, 4, 4, 3, 2, 3};

  // operator bytes in kind order, starting at KIND_LPAREN
  localparam logic [7:0] OP_CHAR [10] = '{"(", ")", ",", ";", "+", "-", "*", "<", "=", "!"};

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_NUMBER
  } scan_mode_e;

  typedef struct packed {
    logic [KindWidth-1:0]   kind;
    logic [StartWidth-1:0]  start;
    logic [LengthWidth-1:0] length;
    logic                   last;
  } token_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       em;
  } byte_word_t;

  // directed row: byte, end marker, and the last token it gives where that is obvious
  typedef struct packed {
    logic [7:0]             ch;
    logic                   em;
    logic                   typed;
    logic [KindWidth-1:0]   kind;
    logic [StartWidth-1:0]  start;
    logic [LengthWidth-1:0] length;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{"(",   1'b0, 1'b1, KIND_LPAREN, 32'd0,  16'd1},  // operator at offset 0
    '{"d",   1'b0, 1'b0, KIND_END,    32'd0,  16'd0},
    '{"e",   1'b0, 1'b0, KIND_END,    32'd0,  16'd0},
    '{"f",   1'b0, 1'b0, KIND_END,    32'd0,  16'd0},
    '{8'd9,  1'b0, 1'b1, KIND_DEF,    32'd1,  16'd3},  // tab ends keyword def
    '{"9",   1'b0, 1'b0, KIND_END,    32'd0,  16'd0},
    '{".",   1'b0, 1'b0, KIND_END,    32'd0,  16'd0},
    '{".",   1'b0, 1'b1, KIND_NUMBER, 32'd5,  16'd2},  // second dot splits the number
    '{")",   1'b0, 1'b1, KIND_RPAREN, 32'd8,  16'd1},  // pending number first, then op
    '{",",   1'b0, 1'b1, KIND_COMMA,  32'd9,  16'd1},
    '{";",   1'b0, 1'b1, KIND_SEMI,   32'd10, 16'd1},
    '{"+",   1'b0, 1'b1, KIND_PLUS,   32'd11, 16'd1},
    '{"-",   1'b0, 1'b1, KIND_MINUS,  32'd12, 16'd1},
    '{"*",   1'b0, 1'b1, KIND_STAR,   32'd13, 16'd1},
    '{"<",   1'b0, 1'b1, KIND_LESS,   32'd14, 16'd1},
    '{"=",   1'b0, 1'b1, KIND_EQUAL,  32'd15, 16'd1},
    '{"!",   1'b0, 1'b1, KIND_BANG,   32'd16, 16'd1},
    '{8'hFF, 1'b0, 1'b1, KIND_ERROR,  32'd17, 16'd1},  // top byte value is unknown
    '{"a",   1'b0, 1'b0, KIND_END,    32'd0,  16'd0},  // discarded while halted
    '{8'hFF, 1'b1, 1'b1, KIND_END,    32'd19, 16'd0},  // end marker, byte ignored
    '{"_",   1'b0, 1'b0, KIND_END,    32'd0,  16'd0},  // new stream from offset 0
    '{"Z",   1'b0, 1'b0, KIND_END,    32'd0,  16'd0},
    '{"9",   1'b0, 1'b0, KIND_END,    32'd0,  16'd0},
    '{8'h00, 1'b0, 1'b1, KIND_ERROR,  32'd3,  16'd1},  // identifier flushed, then error
    '{8'h00, 1'b1, 1'b1, KIND_END,    32'd4,  16'd0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   push;
  logic                   full;
  logic [7:0]             ch_i;
  logic                   end_marker_i;
  logic                   empty;
  logic                   pop;
  logic [KindWidth-1:0]   kind_o;
  logic [StartWidth-1:0]  start_offset_o;
  logic [LengthWidth-1:0] length_o;
  logic                   last_o;

  keyword_number_operator_lexer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .ch_i           (ch_i),
    .end_marker_i   (end_marker_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .start_offset_o (start_offset_o),
    .length_o       (length_o),
    .last_o         (last_o)
  );

  // lexer state mirrored by the predictor
  scan_mode_e             scan_mode;
  logic                   dot_seen;
  logic [7:0]             kw_alive;
  logic [LengthWidth-1:0] tok_len;
  logic [StartWidth-1:0]  tok_start;
  logic [StartWidth-1:0]  byte_pos;
  logic                   halted;

  token_t      pending_tokens[$];  // tokens predicted but not yet popped
  byte_word_t  stream_q[$];        // random stream under construction
  int unsigned failures;
  int unsigned live_words;         // words that reached the lexer, discarded ones excluded

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic clear_scan();
    scan_mode = SCAN_IDLE;
    dot_seen  = 1'b0;
    kw_alive  = 8'hFF;
    tok_len   = '0;
    tok_start = '0;
  endtask

  task automatic open_token(input scan_mode_e m);
    scan_mode = m;
    dot_seen  = 1'b0;
    kw_alive  = 8'hFF;
    tok_len   = '0;
    tok_start = byte_pos;
  endtask

  task automatic add_token_word(input logic [KindWidth-1:0] k,
                                input logic [StartWidth-1:0] s,
                                input logic [LengthWidth-1:0] l);
    pending_tokens.push_back('{kind: k, start: s, length: l, last: 1'b0});
  endtask

  // append one byte, knocking out keywords that no longer match
  task automatic grow_token(input logic [7:0] c);
    int idx;
    idx = int'(tok_len);
    if (scan_mode == SCAN_IDENT) begin
      for (int k = 0; k < 8; k++) begin
        if (idx >= KW_LEN[k]) kw_alive[k] = 1'b0;
        else if (KW_TEXT[k][8*(KW_LEN[k]-1-idx) +: 8] != c) kw_alive[k] = 1'b0;
      end
    end
    if (tok_len != '1) tok_len = tok_len + 1'b1;
  endtask

  task automatic flush_token();
    logic [KindWidth-1:0] k;
    if (scan_mode == SCAN_IDENT) begin
      k = KIND_IDENT;
      // walk down so the lowest matching keyword wins
      for (int i = 7; i >= 0; i--) begin
        if (kw_alive[i] && int'(tok_len) == KW_LEN[i]) k = KIND_DEF + i[4:0];
      end
      add_token_word(k, tok_start, tok_len);
    end else if (scan_mode == SCAN_NUMBER) begin
      add_token_word(KIND_NUMBER, tok_start, tok_len);
    end
    clear_scan();
  endtask

  // one accepted byte word: queue the tokens it gives and mark the last one
  task automatic lex_byte(input logic [7:0] c, input logic em);
    int                   n0;
    logic                 letter;
    logic                 digit;
    logic                 num_ch;
    logic [KindWidth-1:0] k;
    token_t               t;
    n0     = pending_tokens.size();
    letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    digit  = (c >= "0" && c <= "9");
    num_ch = digit || c == ".";
    if (em) begin
      flush_token();
      add_token_word(KIND_END, byte_pos, '0);
      byte_pos = '0;
      halted   = 1'b0;
    end else begin
      if (!halted) begin
        if (scan_mode == SCAN_IDENT && (letter || digit || c == "_")) begin
          grow_token(c);
        end else if (scan_mode == SCAN_NUMBER && num_ch && !(c == "." && dot_seen)) begin
          if (c == ".") dot_seen = 1'b1;
          grow_token(c);
        end else begin
          flush_token();
          if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
            // separator only
          end else if (letter || c == "_") begin
            open_token(SCAN_IDENT);
            grow_token(c);
          end else if (num_ch) begin
            open_token(SCAN_NUMBER);
            if (c == ".") dot_seen = 1'b1;
            grow_token(c);
          end else begin
            k = KIND_ERROR;
            for (int i = 9; i >= 0; i--) begin
              if (OP_CHAR[i] == c) k = KIND_LPAREN + i[4:0];
            end
            add_token_word(k, byte_pos, 16'd1);
            if (k == KIND_ERROR) halted = 1'b1;
          end
        end
      end
      byte_pos = byte_pos + 1'b1;
    end
    if (pending_tokens.size() > n0) begin
      t = pending_tokens[$];
      t.last = 1'b1;
      pending_tokens[pending_tokens.size()-1] = t;
    end
  endtask

  // ---------------------------------------------------------------------------
  // byte side
  // ---------------------------------------------------------------------------

  // offer one byte word after gap idle cycles and return at the edge that takes it
  task automatic send_word(input logic [7:0] c, input logic em, input int unsigned gap);
    logic was_halted;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    ch_i         <= c;
    end_marker_i <= em;
    do @(posedge clk_i); while (full);
    was_halted = halted;
    lex_byte(c, em);
    if (em || !was_halted) live_words++;
  endtask

  // hold the byte side until every predicted token has been popped
  task automatic drain_tokens();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_tokens.size() != 0);
  endtask

  function automatic logic [7:0] ident_char(input bit first);
    int unsigned r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  task automatic add_byte(input logic [7:0] c);
    stream_q.push_back('{ch: c, em: 1'b0});
  endtask

  // one random token, mostly well formed, with a little noise
  task automatic add_random_token();
    int unsigned pick;
    int unsigned k;
    int unsigned len;
    int unsigned twist;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // keyword, sometimes one byte short or one byte long
      k     = $urandom_range(0, 7);
      len   = KW_LEN[k];
      twist = $urandom_range(0, 7);
      if (twist == 0) len--;
      for (int i = 0; i < len; i++) add_byte(KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8]);
      if (twist == 1) add_byte(ident_char(1'b0));
    end else if (pick < 45) begin
      add_byte(ident_char(1'b1));
      repeat ($urandom_range(0, 7)) add_byte(ident_char(1'b0));
    end else if (pick < 65) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 3) == 0) add_byte(".");
        else add_byte(8'("0" + $urandom_range(0, 9)));
      end
    end else if (pick < 81) begin
      add_byte(OP_CHAR[$urandom_range(0, 9)]);
    end else if (pick < 98) begin
      k = $urandom_range(0, 5);
      add_byte(k == 5 ? 8'd32 : 8'(9 + k));
    end else begin
      // any byte at all, which usually halts the stream
      add_byte(8'($urandom_range(0, 255)));
    end
    // words usually get a separator so keywords stay whole
    if (pick < 65 && $urandom_range(0, 2) != 0) add_byte(8'd32);
  endtask

  task automatic build_stream();
    stream_q.delete();
    repeat ($urandom_range(1, 25)) add_random_token();
    stream_q.push_back('{ch: 8'($urandom_range(0, 255)), em: 1'b1});
  endtask

  // main sequence: reset, directed table, random streams
  initial begin
    int unsigned next_drain;
    bit          calm;
    token_t      t;
    rst_ni       = 1'b0;
    push         = 1'b0;
    ch_i         = 8'h00;
    end_marker_i = 1'b0;
    failures     = 0;
    live_words   = 0;
    byte_pos     = '0;
    halted       = 1'b0;
    clear_scan();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; typed rows replace the predicted last token of their word
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(DIRECTED[i].ch, DIRECTED[i].em, $urandom_range(0, 3));
      if (DIRECTED[i].typed) begin
        t = '{kind: DIRECTED[i].kind, start: DIRECTED[i].start,
              length: DIRECTED[i].length, last: 1'b1};
        pending_tokens[pending_tokens.size()-1] = t;
      end
    end
    drain_tokens();

    // random streams, each ending in an end marker; some run with no gaps
    live_words = 0;
    next_drain = DRAIN_EVERY;
    while (live_words < RANDOM_WORDS) begin
      build_stream();
      calm = ($urandom_range(0, 3) == 0);
      foreach (stream_q[i]) begin
        send_word(stream_q[i].ch, stream_q[i].em, calm ? 0 : $urandom_range(0, 12));
      end
      if (live_words >= next_drain) begin
        drain_tokens();
        next_drain += DRAIN_EVERY;
      end
    end

    drain_tokens();
    repeat (SETTLE) @(posedge clk_i);
    if (failures == 0 && pending_tokens.size() == 0) begin
      $display("keyword_number_operator_lexer_tb passed");
    end else begin
      $display("keyword_number_operator_lexer_tb failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // token side
  // ---------------------------------------------------------------------------

  // pop with random stalls, switching now and then to a stretch of no stalls
  initial begin
    int unsigned stall;
    bit          calm;
    pop  = 1'b0;
    calm = 1'b0;
    wait (rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if ($urandom_range(0, 49) == 0) calm = !calm;
    end
  end

  // compare every popped token word with the oldest prediction
  always @(posedge clk_i) begin : token_check
    token_t want;
    token_t got;
    if (rst_ni && pop && !empty) begin
      got = '{kind: kind_o, start: start_offset_o, length: length_o, last: last_o};
      if (pending_tokens.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected token word: kind %0d start %0d length %0d last %0d",
                   got.kind, got.start, got.length, got.last);
        end
      end else begin
        want = pending_tokens.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10) begin
            $display("token mismatch: expected kind %0d start %0d length %0d last %0d",
                     want.kind, want.start, want.length, want.last);
            $display("                actual   kind %0d start %0d length %0d last %0d",
                     got.kind, got.start, got.length, got.last);
          end
        end
      end
    end
  end

  // watchdog: too long with nothing moving on either side ends the run
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("keyword_number_operator_lexer_tb failed");
    $finish;
  end

endmodule
